// ===== src/lg2_pkg.sv =====
// Shared types and constants for the fast log2/ln approximation pipeline.
// No dependencies.
package lg2_pkg;

  // Coefficients as signed Q.40 integers
  localparam logic signed [63:0] Q40_C2  = -64'sd379164858605;
  localparam logic signed [63:0] Q40_C1  = 64'sd2226143567470;
  localparam logic signed [63:0] Q40_C0  = 64'sd742035757530;
  localparam logic signed [63:0] Q40_LN2 = 64'shB17217F7D2;

  localparam logic [31:0] NEG_INF_BITS  = 32'hFF800000;
  localparam logic [31:0] NAN_BITS      = 32'h7F800001;
  localparam logic [31:0] ONE_BITS      = 32'h3F800000;
  localparam logic [31:0] POS_ZERO_BITS = 32'h00000000;

  localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;
  localparam logic [8:0] EXP_OFFSET    = 9'd128;
  // biased exponent = EXP_NORM_BASE - leading zeros of the (F+8)-bit magnitude
  localparam logic [7:0] EXP_NORM_BASE = 8'd134;

  localparam int PIPE_DEPTH = 6;

  typedef struct packed {
    logic        nat_log;
    logic        spec_hit;
    logic [31:0] spec_bits;
  } side_t;

  // Round a Q.40 constant to Q.f, half up (arithmetic shift is floor)
  function automatic logic signed [63:0] q40_to_qf(input logic signed [63:0] c40,
                                                   input int unsigned f);
    logic signed [63:0] rnd;
    rnd = 64'sd1 <<< (39 - f);
    return (c40 + rnd) >>> (40 - f);
  endfunction

endpackage

// ===== src/lg2_in_if.sv =====
// Input channel: operand bit pattern and log base select.
// No dependencies.
interface lg2_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;
  logic        operation;

  modport source (output valid, output operand_bits, output operation, input ready);
  modport sink   (input valid, input operand_bits, input operation, output ready);
endinterface

// ===== src/lg2_out_if.sv =====
// Result channel: single precision bit pattern of the logarithm.
// No dependencies.
interface lg2_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

// ===== src/fast_log2_approx_float_top.sv =====
// Top level of the approximate log2 / ln unit for single precision operands.
// Depends on lg2_pkg, lg2_in_if, lg2_out_if, lg2_front, lg2_poly, lg2_scale, lg2_pack.
//
// Six-stage pipeline: one item per clock unless the output stalls. Stages:
// special-case decode, C2*M+C1 multiply, t*M multiply plus exponent, optional
// ln2 multiply, byte normalize, bit normalize and pack into the output register.
// Every stage has its own valid bit and stalls only when it is full and the
// stage after it cannot move, so empty slots fill while the output is held and
// nothing is lost or repeated.
// Zeros, exactly 1.0 and negative non-NaN operands give fixed patterns in
// both modes; all other operands go through the fixed-point formula.
module fast_log2_approx_float_top import lg2_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  lg2_in_if.sink    in_ch,
  lg2_out_if.source out_ch
);

  logic                        f_vld, f_rdy;
  logic [FRAC_BITS:0]          f_mant;
  logic [7:0]                  f_expo;
  side_t                       f_side;
  logic                        p_vld, p_rdy;
  logic signed [FRAC_BITS+8:0] p_sum;
  side_t                       p_side;
  logic                        s_vld, s_rdy;
  logic signed [FRAC_BITS+8:0] s_val;
  side_t                       s_side;

  lg2_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_in     (in_ch.valid),
    .ready_out    (in_ch.ready),
    .operand_bits (in_ch.operand_bits),
    .operation    (in_ch.operation),
    .valid_out    (f_vld),
    .ready_in     (f_rdy),
    .mant         (f_mant),
    .expo         (f_expo),
    .side         (f_side)
  );

  lg2_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (f_vld),
    .ready_out (f_rdy),
    .mant      (f_mant),
    .expo      (f_expo),
    .side_in   (f_side),
    .valid_out (p_vld),
    .ready_in  (p_rdy),
    .sum       (p_sum),
    .side_out  (p_side)
  );

  lg2_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (p_vld),
    .ready_out (p_rdy),
    .sum_in    (p_sum),
    .side_in   (p_side),
    .valid_out (s_vld),
    .ready_in  (s_rdy),
    .sum_out   (s_val),
    .side_out  (s_side)
  );

  lg2_pack #(.FRAC_BITS(FRAC_BITS)) u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_in    (s_vld),
    .ready_out   (s_rdy),
    .val_in      (s_val),
    .side_in     (s_side),
    .valid_out   (out_ch.valid),
    .ready_in    (out_ch.ready),
    .result_bits (out_ch.result_bits)
  );

endmodule

// ===== src/lg2_front.sv =====
// Stage 1: special-case decode and mantissa extraction.
// Depends on lg2_pkg.
module lg2_front import lg2_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_in,
  output logic               ready_out,
  input  logic [31:0]        operand_bits,
  input  logic               operation,
  output logic               valid_out,
  input  logic               ready_in,
  output logic [FRAC_BITS:0] mant,
  output logic [7:0]         expo,
  output side_t              side
);

  logic               vld_r;
  logic               adv;
  logic [FRAC_BITS:0] mant_r, mant_nxt;
  logic [7:0]         expo_r;
  side_t              side_r, side_nxt;
  logic [63:0]        mant_ext;
  logic               is_nan;

  assign adv       = !vld_r || ready_in;
  assign ready_out = adv;

  assign mant_ext = {1'b1, operand_bits[22:0], 40'd0};
  assign mant_nxt = mant_ext[63 -: FRAC_BITS+1];
  assign is_nan   = (operand_bits[30:23] == EXP_ALL_ONES) && (operand_bits[22:0] != 23'd0);

  always_comb begin
    side_nxt.nat_log   = operation;
    side_nxt.spec_hit  = 1'b0;
    side_nxt.spec_bits = POS_ZERO_BITS;
    if (operand_bits[30:0] == 31'd0) begin
      side_nxt.spec_hit  = 1'b1;
      side_nxt.spec_bits = NEG_INF_BITS;
    end else if (operand_bits == ONE_BITS) begin
      side_nxt.spec_hit  = 1'b1;
      side_nxt.spec_bits = POS_ZERO_BITS;
    end else if (operand_bits[31] && !is_nan) begin
      side_nxt.spec_hit  = 1'b1;
      side_nxt.spec_bits = NAN_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_in) begin
      mant_r <= mant_nxt;
      expo_r <= operand_bits[30:23];
      side_r <= side_nxt;
    end
  end

  assign valid_out = vld_r;
  assign mant      = mant_r;
  assign expo      = expo_r;
  assign side      = side_r;

endmodule

// ===== src/lg2_poly.sv =====
// Stages 2-3: quadratic in the mantissa plus the exponent less 128, fixed point.
// Depends on lg2_pkg.
module lg2_poly import lg2_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_in,
  output logic                        ready_out,
  input  logic [FRAC_BITS:0]          mant,
  input  logic [7:0]                  expo,
  input  side_t                       side_in,
  output logic                        valid_out,
  input  logic                        ready_in,
  output logic signed [FRAC_BITS+8:0] sum,
  output side_t                       side_out
);

  localparam int CW = FRAC_BITS + 3;
  localparam int MW = FRAC_BITS + 2;
  localparam int PW = CW + MW;
  localparam int QW = FRAC_BITS + 4;
  localparam int SW = FRAC_BITS + 9;
  localparam logic signed [CW-1:0] C2 = CW'(q40_to_qf(Q40_C2, FRAC_BITS));
  localparam logic signed [CW-1:0] C1 = CW'(q40_to_qf(Q40_C1, FRAC_BITS));
  localparam logic signed [CW-1:0] C0 = CW'(q40_to_qf(Q40_C0, FRAC_BITS));

  logic                 vld_a_r, vld_b_r;
  logic                 adv_a, adv_b;
  logic signed [MW-1:0] m_s, m_a_s;
  logic signed [PW-1:0] p1, p2;
  logic signed [CW-1:0] t1_r, t1_nxt;
  logic [FRAC_BITS:0]   mant_a_r;
  logic [7:0]           expo_a_r;
  side_t                side_a_r, side_b_r;
  logic signed [QW-1:0] q;
  logic [8:0]           em;
  logic signed [SW-1:0] sum_r, sum_nxt;

  assign adv_b     = !vld_b_r || ready_in;
  assign adv_a     = !vld_a_r || adv_b;
  assign ready_out = adv_a;

  // stage A: C2*M + C1
  assign m_s    = $signed({1'b0, mant});
  assign p1     = C2 * m_s;
  assign t1_nxt = CW'(p1 >>> FRAC_BITS) + C1;

  // stage B: t*M - C0 + (exp - 128)
  assign m_a_s   = $signed({1'b0, mant_a_r});
  assign p2      = t1_r * m_a_s;
  assign q       = QW'(p2 >>> FRAC_BITS) - QW'(C0);
  assign em      = {1'b0, expo_a_r} - EXP_OFFSET;
  assign sum_nxt = $signed({em, {FRAC_BITS{1'b0}}}) + SW'(q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= valid_in;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && valid_in) begin
      t1_r     <= t1_nxt;
      mant_a_r <= mant;
      expo_a_r <= expo;
      side_a_r <= side_in;
    end
    if (adv_b && vld_a_r) begin
      sum_r    <= sum_nxt;
      side_b_r <= side_a_r;
    end
  end

  assign valid_out = vld_b_r;
  assign sum       = sum_r;
  assign side_out  = side_b_r;

endmodule

// ===== src/lg2_scale.sv =====
// Stage 4: optional scaling by ln2 for the natural log, floor rounding.
// Depends on lg2_pkg.
module lg2_scale import lg2_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_in,
  output logic                        ready_out,
  input  logic signed [FRAC_BITS+8:0] sum_in,
  input  side_t                       side_in,
  output logic                        valid_out,
  input  logic                        ready_in,
  output logic signed [FRAC_BITS+8:0] sum_out,
  output side_t                       side_out
);

  localparam int SW = FRAC_BITS + 9;
  localparam int PW = SW + FRAC_BITS + 1;
  localparam logic [FRAC_BITS-1:0] LN2 = FRAC_BITS'(q40_to_qf(Q40_LN2, FRAC_BITS));

  logic                  vld_r;
  logic                  adv;
  logic signed [FRAC_BITS:0] ln2_s;
  logic signed [PW-1:0]  prod;
  logic signed [SW-1:0]  val_r, val_nxt;
  side_t                 side_r;

  assign adv       = !vld_r || ready_in;
  assign ready_out = adv;

  assign ln2_s   = $signed({1'b0, LN2});
  assign prod    = sum_in * ln2_s;
  assign val_nxt = side_in.nat_log ? SW'(prod >>> FRAC_BITS) : sum_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && valid_in) begin
      val_r  <= val_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = vld_r;
  assign sum_out   = val_r;
  assign side_out  = side_r;

endmodule

// ===== src/lg2_pack.sv =====
// Stages 5-6: fixed point to single precision, byte then bit normalization.
// Depends on lg2_pkg.
module lg2_pack import lg2_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_in,
  output logic                        ready_out,
  input  logic signed [FRAC_BITS+8:0] val_in,
  input  side_t                       side_in,
  output logic                        valid_out,
  input  logic                        ready_in,
  output logic [31:0]                 result_bits
);

  localparam int SW  = FRAC_BITS + 9;
  localparam int MW  = FRAC_BITS + 8;
  localparam int NW  = ((MW + 7) / 8) * 8;
  localparam int NB  = NW / 8;
  localparam int ZBW = $clog2(NB);

  logic                 vld_a_r, vld_b_r;
  logic                 adv_a, adv_b;
  logic signed [SW-1:0] v_abs;
  logic [NW-1:0]        w, wc_nxt, wc_r, wn;
  logic [ZBW-1:0]       zb_nxt, zb_r;
  logic                 byte_found, bit_found;
  logic                 sign_r, zero_r;
  side_t                side_a_r;
  logic [2:0]           lzf;
  logic [7:0]           expo;
  logic [31:0]          res_nxt, res_r;

  assign adv_b     = !vld_b_r || ready_in;
  assign adv_a     = !vld_a_r || adv_b;
  assign ready_out = adv_a;

  // stage A: magnitude, coarse (byte) leading-zero shift
  assign v_abs = val_in[SW-1] ? -val_in : val_in;
  assign w     = NW'(v_abs[MW-1:0]) << (NW - MW);

  always_comb begin
    zb_nxt     = '0;
    byte_found = 1'b0;
    for (int i = 0; i < NB; i++) begin
      if (!byte_found && (w[NW-1-8*i -: 8] != 8'd0)) begin
        zb_nxt     = ZBW'(i);
        byte_found = 1'b1;
      end
    end
  end

  assign wc_nxt = w << {zb_nxt, 3'b000};

  // stage B: fine shift and pack
  always_comb begin
    lzf       = 3'd0;
    bit_found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!bit_found && wc_r[NW-1-i]) begin
        lzf       = 3'(i);
        bit_found = 1'b1;
      end
    end
  end

  assign wn   = wc_r << lzf;
  assign expo = EXP_NORM_BASE - 8'({zb_r, lzf});

  always_comb begin
    if (side_a_r.spec_hit) begin
      res_nxt = side_a_r.spec_bits;
    end else if (zero_r) begin
      res_nxt = POS_ZERO_BITS;
    end else begin
      res_nxt = {sign_r, expo, wn[NW-2 -: 23]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (adv_a) begin
        vld_a_r <= valid_in;
      end
      if (adv_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && valid_in) begin
      wc_r     <= wc_nxt;
      zb_r     <= zb_nxt;
      sign_r   <= val_in[SW-1];
      zero_r   <= (val_in == '0);
      side_a_r <= side_in;
    end
    if (adv_b && vld_a_r) begin
      res_r <= res_nxt;
    end
  end

  assign valid_out   = vld_b_r;
  assign result_bits = res_r;

endmodule

// ===== src/lg2_chk.sv =====
// Port-level checks for the log approximation pipeline, bound to the top level.
// Depends on lg2_pkg and fast_log2_approx_float_top.
module lg2_chk import lg2_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result
);

  logic [2:0] cnt_r, cnt_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cnt_nxt = cnt_r + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage is empty");

  a_no_phantom_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != 3'd0))
    else $error("result shown with no item in flight");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed or dropped");

endmodule

bind fast_log2_approx_float_top lg2_chk u_lg2_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result_bits)
);

// ===== sim/fast_log2_approx_float_top_tb.sv =====
// Testbench for fast_log2_approx_float_top: directed and random operands in both log modes,
// with random source gaps and sink stalls, checked against an in-bench fixed-point predictor.
// Depends on lg2_pkg, lg2_in_if, lg2_out_if and the RTL under src.
`timescale 1ns / 100ps

module fast_log2_approx_float_top_tb;

  localparam int FRAC_BITS = 24;
  localparam int LATENCY = 6;
  localparam int RANDOM_ITEMS = 1830;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic OP_LOG2 = 1'b0;
  localparam logic OP_LN = 1'b1;

  localparam longint C2_Q40 = -64'sd379164858605;
  localparam longint C1_Q40 = 64'sd2226143567470;
  localparam longint C0_Q40 = 64'sd742035757530;
  localparam longint LN2_Q40 = 64'shB17217F7D2;

  localparam logic [31:0] MINUS_INF = 32'hFF800000;
  localparam logic [31:0] QUIET_NAN = 32'h7F800001;
  localparam logic [31:0] FP_ONE = 32'h3F800000;
  localparam logic [31:0] FP_ZERO = 32'h00000000;

  class log_scoreboard;
    logic [31:0] expected_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function longint q40_to_frac(longint c40);
      int s;
      s = 40 - FRAC_BITS;
      return (c40 + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function logic [31:0] fixed_to_float(longint v);
      logic [63:0] mag;
      logic        sgn;
      logic [22:0] fr;
      logic [7:0]  ex;
      int          p;
      if (v == 0) return FP_ZERO;
      sgn = (v < 0);
      mag = sgn ? 64'(-v) : 64'(v);
      p = 0;
      for (int i = 0; i < 64; i++) begin
        if (mag[i]) p = i;
      end
      if (p > 23) fr = 23'(mag >> (p - 23));
      else fr = 23'(mag << (23 - p));
      ex = 8'(p - FRAC_BITS + 127);
      return {sgn, ex, fr};
    endfunction

    function logic [31:0] approx_log(logic [31:0] x, logic op);
      logic [7:0]  ex;
      logic [22:0] fr;
      logic        is_nan;
      longint      m, t, acc;
      ex = x[30:23];
      fr = x[22:0];
      is_nan = (ex == 8'hFF) && (fr != 0);
      if (x[30:0] == 0) return MINUS_INF;
      if (x == FP_ONE) return FP_ZERO;
      if (x[31] && !is_nan) return QUIET_NAN;
      m = longint'(1) << FRAC_BITS;
      if (FRAC_BITS >= 23) m = m | (longint'(fr) << (FRAC_BITS - 23));
      else m = m | (longint'(fr) >> (23 - FRAC_BITS));
      t = ((q40_to_frac(C2_Q40) * m) >>> FRAC_BITS) + q40_to_frac(C1_Q40);
      t = ((t * m) >>> FRAC_BITS) - q40_to_frac(C0_Q40);
      acc = (longint'(ex) - 128) * (longint'(1) << FRAC_BITS) + t;
      if (op == OP_LN) acc = (acc * q40_to_frac(LN2_Q40)) >>> FRAC_BITS;
      return fixed_to_float(acc);
    endfunction

    function void note_operand(logic [31:0] x, logic op);
      expected_q.push_back(approx_log(x, op));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (expected_q.size() == 0) begin
        $display("%0t: result_bits %h with no item outstanding", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        $display("%0t: result_bits expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  bit   src_burst = 1'b0;
  bit   snk_burst = 1'b0;

  lg2_in_if  in_ch();
  lg2_out_if out_ch();

  log_scoreboard sb = new();

  fast_log2_approx_float_top #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result_bits);
  end

  // sink: random stall before each item, with stretches of no stall
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if ($urandom_range(0, 47) == 0) snk_burst = ~snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_operand(logic [31:0] x, logic op);
    int gap;
    if ($urandom_range(0, 47) == 0) src_burst = ~src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operand_bits <= x;
    in_ch.operation <= op;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operand(x, op);
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4: r[31:23] = {1'b0, 8'($urandom_range(1, 254))};
      5: r[31:23] = {1'b0, 8'($urandom_range(126, 127))};
      6: r[30:23] = 8'h00;
      7: r[30:23] = 8'hFF;
      8: begin
        case ($urandom_range(0, 3))
          0: r = FP_ZERO;
          1: r = 32'h80000000;
          2: r = FP_ONE;
          default: r = MINUS_INF;
        endcase
      end
      default: r[31] = 1'b0;
    endcase
    return r;
  endfunction

  initial begin
    logic [31:0] directed[12];
    directed = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'hC0000000,
                 32'hFF800000, 32'h80000001, 32'hFFC00001, 32'h7F800000,
                 32'h7FFFFFFF, 32'h00000001, 32'h3F7FFFFF, 32'h7F7FFFFF};
    in_ch.valid <= 1'b0;
    in_ch.operand_bits <= '0;
    in_ch.operation <= OP_LOG2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_operand(directed[i], OP_LOG2);
      send_operand(directed[i], OP_LN);
    end
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      send_operand(random_operand(), 1'($urandom_range(0, 1)));
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (4 * LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
